@@ design/pps_pkg.sv @@
// Shared codes and types of the preemptive priority scheduler.
`default_nettype none

package pps_pkg;

  localparam int TIME_W = 32;

  // Operation codes; the unused code behaves as clear.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [2:0] STAT_LOADED = 3'd0;
  localparam logic [2:0] STAT_FULL   = 3'd1;
  localparam logic [2:0] STAT_ZERO   = 3'd2;
  localparam logic [2:0] STAT_RAN    = 3'd3;
  localparam logic [2:0] STAT_IDLE   = 3'd4;
  localparam logic [2:0] STAT_DONE   = 3'd5;

  // One table entry as held in the process memory.
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] remaining;
    logic [7:0]  prio;
  } entry_t;

endpackage

`default_nettype wire

@@ design/pps_table.sv @@
// Process table memory: one write port, one read port with registered data.
`default_nettype none

module pps_table
  import pps_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire entry_t            wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output entry_t                 rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/pps_sel.sv @@
// Shared comparator that keeps the best ready entry seen during a scan.
`default_nettype none

module pps_sel
  import pps_pkg::*;
#(
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              init,
  input  wire logic              en,
  input  wire logic [ADDR_W-1:0] slot,
  input  wire entry_t            cand,
  input  wire logic [TIME_W-1:0] now,
  output logic                   found,
  output entry_t                 best,
  output logic [ADDR_W-1:0]      best_slot
);

  logic ready;
  logic better;

  assign ready  = (cand.remaining != 16'd0) && ({16'd0, cand.arrival} <= now);
  // Strict less-than keeps the lower slot on a tie, since slots arrive in order.
  assign better = !found || (cand.prio < best.prio);

  always_ff @(posedge clk) begin
    if (rst || init) begin
      found <= 1'b0;
    end else if (en && ready && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!init && en && ready && better) begin
      best      <= cand;
      best_slot <= slot;
    end
  end

endmodule

`default_nettype wire

@@ design/preemptive_priority_scheduler_top.sv @@
// Top level of the preemptive priority scheduler: sequencer, counters and result registers.
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------------------
//  command   | start / busy       | operation, arrival_time, burst_time, priority_level
//  result    | done (one cycle)   | status, running_id, finished, completion_time,
//            |                    | turnaround_time, time_now
//
// For load, clear and a tick with no unfinished work, the result strobe
// follows in the next cycle and busy stays low.
// A tick with work reads the table memory one entry per cycle in S_SCAN into a
// single shared comparator, passes through S_DRAIN, and then in S_UPDATE writes back
// the served entry, if any. The result strobe comes in the first cycle with busy low
// again.
// Synchronous reset empties the table and sets time to zero; no clearing pass is needed
// because only slots below the load count are ever read.
// The receiver cannot stall; the done strobe of each result is high for exactly one cycle.
`default_nettype none

module preemptive_priority_scheduler_top
  import pps_pkg::*;
#(
  parameter int MAX_PROCESSES = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [1:0]                           operation,
  input  wire logic [15:0]                          arrival_time,
  input  wire logic [15:0]                          burst_time,
  input  wire logic [7:0]                           priority_level,
  output logic                                      done,
  output logic [2:0]                                status,
  output logic [$clog2(MAX_PROCESSES+1)-1:0]        running_id,
  output logic                                      finished,
  output logic [TIME_W-1:0]                         completion_time,
  output logic [TIME_W-1:0]                         turnaround_time,
  output logic [TIME_W-1:0]                         time_now
);

  localparam int ADDR_W = $clog2(MAX_PROCESSES);
  localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    loaded_count;
  logic [CNT_W-1:0]    unfinished_count;
  logic [TIME_W-1:0]   current_time;
  logic [TIME_W-1:0]   tick_time;
  logic [ADDR_W-1:0]   idx;
  logic                rd_valid;
  logic [ADDR_W-1:0]   rd_slot;

  logic                accept;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  entry_t              wdata;
  entry_t              rdata;
  logic                sel_init;
  logic                found;
  entry_t              best;
  logic [ADDR_W-1:0]   best_slot;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  pps_table #(
    .DEPTH  (MAX_PROCESSES),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  pps_sel #(
    .ADDR_W (ADDR_W)
  ) u_sel (
    .clk       (clk),
    .rst       (rst),
    .init      (sel_init),
    .en        (rd_valid),
    .slot      (rd_slot),
    .cand      (rdata),
    .now       (current_time),
    .found     (found),
    .best      (best),
    .best_slot (best_slot)
  );

  // Memory writes come from a load transfer or from the write-back of a served entry.
  always_comb begin
    we       = 1'b0;
    waddr    = loaded_count[ADDR_W-1:0];
    wdata    = '{arrival: arrival_time, remaining: burst_time, prio: priority_level};
    sel_init = 1'b0;
    if (accept && operation == OP_LOAD
        && loaded_count < CNT_W'(MAX_PROCESSES) && burst_time != 16'd0) begin
      we = 1'b1;
    end
    if (accept && operation == OP_TICK) begin
      sel_init = 1'b1;
    end
    if (state == S_UPDATE && found) begin
      we    = 1'b1;
      waddr = best_slot;
      wdata = '{arrival: best.arrival, remaining: best.remaining - 16'd1, prio: best.prio};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      loaded_count     <= '0;
      unfinished_count <= '0;
      current_time     <= '0;
      done             <= 1'b0;
      rd_valid         <= 1'b0;
    end else begin
      done     <= 1'b0;
      rd_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            running_id      <= '0;
            finished        <= 1'b0;
            completion_time <= '0;
            turnaround_time <= '0;
            time_now        <= current_time;
            unique case (operation)
              OP_LOAD: begin
                done <= 1'b1;
                if (loaded_count >= CNT_W'(MAX_PROCESSES)) begin
                  status <= STAT_FULL;
                end else if (burst_time == 16'd0) begin
                  status <= STAT_ZERO;
                end else begin
                  status           <= STAT_LOADED;
                  running_id       <= loaded_count + CNT_W'(1);
                  loaded_count     <= loaded_count + CNT_W'(1);
                  unfinished_count <= unfinished_count + CNT_W'(1);
                end
              end
              OP_TICK: begin
                if (unfinished_count == '0) begin
                  done   <= 1'b1;
                  status <= STAT_DONE;
                end else begin
                  state     <= S_SCAN;
                  idx       <= '0;
                  tick_time <= (current_time == '1) ? current_time
                                                    : current_time + TIME_W'(1);
                end
              end
              default: begin
                done             <= 1'b1;
                status           <= STAT_LOADED;
                loaded_count     <= '0;
                unfinished_count <= '0;
                current_time     <= '0;
                time_now         <= '0;
              end
            endcase
          end
        end
        S_SCAN: begin
          rd_valid <= 1'b1;
          rd_slot  <= idx;
          idx      <= idx + ADDR_W'(1);
          if (CNT_W'(idx) == loaded_count - CNT_W'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          state        <= S_IDLE;
          done         <= 1'b1;
          current_time <= tick_time;
          time_now     <= tick_time;
          if (found) begin
            status     <= STAT_RAN;
            running_id <= CNT_W'(best_slot) + CNT_W'(1);
            if (best.remaining == 16'd1) begin
              finished         <= 1'b1;
              completion_time  <= tick_time;
              turnaround_time  <= tick_time - {16'd0, best.arrival};
              unfinished_count <= unfinished_count - CNT_W'(1);
            end
          end else begin
            status <= STAT_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only presented once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // Every accepted command produces a result or keeps the sequencer working.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("accepted command produced nothing");

  a_unfinished_le_loaded: assert property (@(posedge clk) disable iff (rst)
    unfinished_count <= loaded_count)
    else $error("unfinished count exceeds load count");

  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CNT_W'(MAX_PROCESSES))
    else $error("load count beyond table depth");

endmodule

`default_nettype wire
